// ----- hw/rtl/nv12_bilinear_scaler_core_assert.svh -----
// ----------------------------------------------------------------------------
// NV12 scaler assertion macros
// Short forms for the concurrent checks used in the scaler RTL.
// ----------------------------------------------------------------------------
`ifndef NV12_BILINEAR_SCALER_CORE_ASSERT_SVH
`define NV12_BILINEAR_SCALER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define NV12S_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NV12S_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hw/rtl/nv12s_pkg.sv -----
// ----------------------------------------------------------------------------
// NV12 scaler package
// Shared widths, register indexes, transfer payloads and sequencer codes.
// ----------------------------------------------------------------------------
package nv12s_pkg;

	localparam int DIM_W  = 8;
	localparam int POS_W  = 15;
	localparam int STEP_W = 13;
	localparam int CNT_W  = 7;
	localparam int FRAC_W = 8;
	localparam int OFS_W  = 15;
	localparam int PIX_W  = 8;
	localparam int IDX_W  = 8;
	localparam int WGT_W  = 17;
	localparam int ACC_W  = 24;
	// dividend is the source size shifted left by the fraction width
	localparam int DIV_BITS = DIM_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

	localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;
	localparam logic [DIM_W-1:0] DST_ROUND_MASK = 8'hF8;
	localparam logic [8:0] WGT_ONE = 9'h100;

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 8'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 8'd1;
	localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 8'd2;
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 8'd3;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [OFS_W-1:0] src_offset;
		logic [PIX_W-1:0] src_byte;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] chroma_u;
		logic [PIX_W-1:0] chroma_v;
		logic             chroma_valid;
		logic [CNT_W-1:0] out_col;
		logic [CNT_W-1:0] out_row;
		logic             frame_last;
	} out_item_t;

	// status of the step divider towards the sequencer
	typedef struct packed {
		logic              busy;
		logic [STEP_W-1:0] x_step;
		logic [STEP_W-1:0] y_step;
	} step_res_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_RD0  = 7'b0000100,
		ST_RD1  = 7'b0001000,
		ST_RD2  = 7'b0010000,
		ST_MIX  = 7'b0100000,
		ST_DONE = 7'b1000000
	} seq_state_t;

endpackage

// ----- hw/rtl/nv12s_chan_if.sv -----
// ----------------------------------------------------------------------------
// NV12 scaler channel
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface nv12s_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/nv12_bilinear_scaler_core.sv -----
// ----------------------------------------------------------------------------
// NV12 bilinear scaler core
// Frame store loader and raster-order bilinear luma / nearest chroma scaler.
// ----------------------------------------------------------------------------
//  port      | dir | carries
//  in_ch     | in  | kind, src_offset, src_byte (store write or pixel step)
//  out_ch    | out | luma, chroma_u/v, chroma_valid, out_col, out_row, frame_last
//  cfg_*     | in  | register write: enable, index, 8-bit data
//
//  A write item is stored without leaving the idle state. A step item passes
//  through an address and weight state, three states of two-port reads of
//  the frame store (four luma neighbours, then the UV pair), a chroma capture
//  state and the hand-over state, then returns to idle, where the next item
//  can be taken; no item is taken before then.
//  After reset and after each write to a known register the step divider runs,
//  and no item is taken while it is busy. The store needs no clearing pass.
//  A result waits in the output register; the sequencer holds in its last
//  state while the previous result has not been taken.
// ----------------------------------------------------------------------------
module nv12_bilinear_scaler_core import nv12s_pkg::*; #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	nv12s_chan_if.sink       in_ch,
	nv12s_chan_if.source     out_ch,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata
);

	`include "nv12_bilinear_scaler_core_assert.svh"

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int lo, int hi);
		if (int'(v) < lo) return DIM_W'(lo);
		if (int'(v) > hi) return DIM_W'(hi);
		return v;
	endfunction

	seq_state_t       state_q;
	logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [DIM_W-1:0] sw, sh, dw, dh;
	logic             step_start_q;
	step_res_t        step_res;

	logic [CNT_W-1:0] col_q, row_q;
	logic [POS_W-1:0] xpos_q, ypos_q;

	logic [CNT_W-1:0] bx_q, nx_q;
	logic [AW-1:0]    rowb_q, rown_q, crow_q;
	logic [WGT_W-1:0] w00_q, w10_q, w01_q, w11_q;
	logic             cval_q, v_oob_q;
	logic [ACC_W-1:0] acc_q;
	logic [PIX_W-1:0] u_q, v_q;

	logic             out_valid_q;
	out_item_t        out_q;

	logic             in_xfer, out_free;
	logic             we;
	logic [AW-1:0]    raddr_a, raddr_b;
	logic [PIX_W-1:0] rdata_a, rdata_b;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q      <= DIM_RESET;
			src_h_q      <= DIM_RESET;
			dst_w_q      <= DIM_RESET;
			dst_h_q      <= DIM_RESET;
			step_start_q <= 1'b1;
		end else begin
			step_start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH: begin
						src_w_q <= cfg_wdata;
						step_start_q <= 1'b1;
					end
					REG_SRC_HEIGHT: begin
						src_h_q <= cfg_wdata;
						step_start_q <= 1'b1;
					end
					REG_DST_WIDTH: begin
						dst_w_q <= cfg_wdata;
						step_start_q <= 1'b1;
					end
					REG_DST_HEIGHT: begin
						dst_h_q <= cfg_wdata;
						step_start_q <= 1'b1;
					end
					default: begin
						step_start_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign sw = clamp_dim(src_w_q, 2, MAX_WIDTH);
	assign sh = clamp_dim(src_h_q, 2, MAX_HEIGHT);
	assign dw = clamp_dim(dst_w_q, 8, MAX_WIDTH);
	assign dh = clamp_dim(dst_h_q, 8, MAX_HEIGHT);

	nv12s_step_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_start_q),
		.src_w  (sw),
		.src_h  (sh),
		.dst_w  (dw),
		.dst_h  (dh),
		.res    (step_res)
	);

	// ---------------- handshakes ----------------
	assign in_ch.ready = (state_q == ST_IDLE) && !step_res.busy;
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// ---------------- frame store ----------------
	assign we = in_xfer && (in_ch.data.kind == KIND_WRITE)
		&& (int'(in_ch.data.src_offset) < DEPTH);

	// pick read addresses per read phase
	always_comb begin
		raddr_a = AW'(rowb_q + AW'(bx_q));
		raddr_b = AW'(rowb_q + AW'(nx_q));
		case (state_q)
			ST_RD1: begin
				raddr_a = AW'(rown_q + AW'(bx_q));
				raddr_b = AW'(rown_q + AW'(nx_q));
			end
			ST_RD2: begin
				raddr_a = AW'(crow_q + AW'({bx_q[CNT_W-1:1], 1'b0}));
				raddr_b = AW'(crow_q + AW'({bx_q[CNT_W-1:1], 1'b1}));
			end
			default: begin
				raddr_a = AW'(rowb_q + AW'(bx_q));
				raddr_b = AW'(rowb_q + AW'(nx_q));
			end
		endcase
	end

	nv12s_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (AW'(in_ch.data.src_offset)),
		.wdata   (in_ch.data.src_byte),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// ---------------- position and weights ----------------
	logic [CNT_W-1:0] bx_raw, by_raw, bx_c, by_c, nx_c, ny_c;
	logic [FRAC_W-1:0] fx, fy;
	logic [8:0]       ifx, ify;

	always_comb begin
		bx_raw = xpos_q[POS_W-1:FRAC_W];
		by_raw = ypos_q[POS_W-1:FRAC_W];
		fx     = xpos_q[FRAC_W-1:0];
		fy     = ypos_q[FRAC_W-1:0];
		bx_c   = ({1'b0, bx_raw} > sw - 1'b1) ? CNT_W'(sw - 1'b1) : bx_raw;
		by_c   = ({1'b0, by_raw} > sh - 1'b1) ? CNT_W'(sh - 1'b1) : by_raw;
		nx_c   = ({1'b0, bx_c} + 1'b1 < sw) ? CNT_W'(bx_c + 1'b1) : CNT_W'(sw - 1'b1);
		ny_c   = ({1'b0, by_c} + 1'b1 < sh) ? CNT_W'(by_c + 1'b1) : CNT_W'(sh - 1'b1);
		ifx    = WGT_ONE - {1'b0, fx};
		ify    = WGT_ONE - {1'b0, fy};
	end

	// ---------------- frame counters ----------------
	logic [DIM_W-1:0] col_nx, row_nx;
	logic             col_wrap, row_wrap;

	always_comb begin
		col_nx   = {1'b0, col_q} + 1'b1;
		row_nx   = {1'b0, row_q} + 1'b1;
		col_wrap = col_nx >= (dw & DST_ROUND_MASK);
		row_wrap = row_nx >= (dh & DST_ROUND_MASK);
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			xpos_q      <= '0;
			ypos_q      <= '0;
		end else begin
			// drop the result once taken, unless the next one lands this cycle
			if (out_ch.ready && !(state_q == ST_DONE && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_ch.data.kind == KIND_STEP) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_DONE;
				ST_DONE: begin
					// hand over the result and advance the raster position
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (col_wrap) begin
							col_q  <= '0;
							xpos_q <= '0;
							if (row_wrap) begin
								row_q  <= '0;
								ypos_q <= '0;
							end else begin
								row_q  <= row_nx[CNT_W-1:0];
								ypos_q <= POS_W'(ypos_q + POS_W'(step_res.y_step));
							end
						end else begin
							col_q  <= col_nx[CNT_W-1:0];
							xpos_q <= POS_W'(xpos_q + POS_W'(step_res.x_step));
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				bx_q   <= bx_c;
				nx_q   <= nx_c;
				rowb_q <= AW'(AW'(by_c) * AW'(sw));
				rown_q <= AW'(AW'(ny_c) * AW'(sw));
				crow_q <= AW'(AW'(sh) * AW'(sw)) + AW'(AW'(by_c[CNT_W-1:1]) * AW'(sw));
				w00_q  <= WGT_W'(WGT_W'(ifx) * WGT_W'(ify));
				w10_q  <= WGT_W'(WGT_W'(fx) * WGT_W'(ify));
				w01_q  <= WGT_W'(WGT_W'(ifx) * WGT_W'(fy));
				w11_q  <= WGT_W'(WGT_W'(fx) * WGT_W'(fy));
				cval_q <= !col_q[0] && !row_q[0];
			end
			ST_RD1: begin
				acc_q <= ACC_W'(ACC_W'(w00_q) * ACC_W'(rdata_a))
					+ ACC_W'(ACC_W'(w10_q) * ACC_W'(rdata_b));
			end
			ST_RD2: begin
				acc_q   <= acc_q + ACC_W'(ACC_W'(w01_q) * ACC_W'(rdata_a))
					+ ACC_W'(ACC_W'(w11_q) * ACC_W'(rdata_b));
				v_oob_q <= (int'(crow_q) + int'({bx_q[CNT_W-1:1], 1'b1})) >= DEPTH;
			end
			ST_MIX: begin
				u_q <= cval_q ? rdata_a : '0;
				v_q <= (cval_q && !v_oob_q) ? rdata_b : '0;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.luma         <= acc_q[ACC_W-1:ACC_W-PIX_W];
					out_q.chroma_u     <= u_q;
					out_q.chroma_v     <= v_q;
					out_q.chroma_valid <= cval_q;
					out_q.out_col      <= col_q;
					out_q.out_row      <= row_q;
					out_q.frame_last   <= col_wrap && row_wrap;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// ---------------- checks ----------------
	`NV12S_ASSERT_NEXT(a_step_starts, clk, arst_n,
		in_xfer && in_ch.data.kind == KIND_STEP, state_q == ST_PREP,
		"step transfer did not start the sequencer")
	`NV12S_ASSERT_NEXT(a_done_loads, clk, arst_n,
		state_q == ST_DONE && out_free, out_valid_q && state_q == ST_IDLE,
		"finished pixel not handed to output")
	`NV12S_ASSERT_NOW(a_chroma_zero, clk, arst_n,
		out_valid_q && !out_q.chroma_valid, out_q.chroma_u == '0 && out_q.chroma_v == '0,
		"chroma not zero on odd pixel")

endmodule

// ----- hw/rtl/nv12s_ram.sv -----
// ----------------------------------------------------------------------------
// NV12 scaler RAM
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module nv12s_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, and register both reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- hw/rtl/nv12s_step_div.sv -----
// ----------------------------------------------------------------------------
// NV12 scaler step divider
// Restoring divider, one quotient bit per cycle, x and y lanes side by side.
// ----------------------------------------------------------------------------
module nv12s_step_div import nv12s_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIM_W-1:0] src_w,
	input  logic [DIM_W-1:0] src_h,
	input  logic [DIM_W-1:0] dst_w,
	input  logic [DIM_W-1:0] dst_h,
	output step_res_t        res
);

	logic                 run_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIM_W-1:0]     dvx_q, dvy_q;
	logic [DIM_W-1:0]     remx_q, remy_q;
	logic [DIV_BITS-1:0]  quox_q, quoy_q;
	logic [DIM_W:0]       shx, shy;
	logic                 gex, gey;

	// trial subtract on the shifted remainder
	always_comb begin
		shx = {remx_q, quox_q[DIV_BITS-1]};
		shy = {remy_q, quoy_q[DIV_BITS-1]};
		gex = shx >= {1'b0, dvx_q};
		gey = shy >= {1'b0, dvy_q};
	end

	// load on start, then advance one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(DIV_BITS);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvx_q  <= dst_w;
			dvy_q  <= dst_h;
			remx_q <= '0;
			remy_q <= '0;
			quox_q <= {src_w, FRAC_W'(0)};
			quoy_q <= {src_h, FRAC_W'(0)};
		end else if (run_q) begin
			remx_q <= gex ? DIM_W'(shx - {1'b0, dvx_q}) : shx[DIM_W-1:0];
			remy_q <= gey ? DIM_W'(shy - {1'b0, dvy_q}) : shy[DIM_W-1:0];
			quox_q <= {quox_q[DIV_BITS-2:0], gex};
			quoy_q <= {quoy_q[DIV_BITS-2:0], gey};
		end
	end

	assign res.busy   = run_q | start;
	assign res.x_step = quox_q[STEP_W-1:0];
	assign res.y_step = quoy_q[STEP_W-1:0];

endmodule

// ----- verif/nv12s_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// NV12 scaler testbench package
// Frame store depth shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package nv12s_tb_pkg;
	localparam int STORE_DEPTH = 128 * 128 * 3 / 2;
endpackage

// ----- verif/nv12s_scaler_checker.sv -----
// ----------------------------------------------------------------------------
// NV12 scaler checker
// Watches both channels and the register port, predicts each pixel and
// compares the whole item with what the block returns.
// ----------------------------------------------------------------------------
module nv12s_scaler_checker import nv12s_pkg::*, nv12s_tb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending_pixels
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  frame_mem [STORE_DEPTH];
	logic [7:0]  src_w, src_h, dst_w, dst_h;
	logic [6:0]  col_cnt, row_cnt;
	logic [14:0] x_pos, y_pos;
	logic [12:0] x_inc, y_inc;
	out_item_t   pixel_queue [$];

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo);
		if (v < lo) return lo;
		if (v > 128) return 128;
		return v;
	endfunction

	function automatic int unsigned mem_byte(int unsigned a);
		if (a >= STORE_DEPTH) return 0;
		return frame_mem[a];
	endfunction

	// Recompute the accumulator increments from the current sizes
	function automatic void update_steps();
		x_inc = 13'((clamp_dim(src_w, 2) << 8) / clamp_dim(dst_w, 8));
		y_inc = 13'((clamp_dim(src_h, 2) << 8) / clamp_dim(dst_h, 8));
	endfunction

	// Work out the next destination pixel and advance the raster counters
	function automatic out_item_t next_pixel();
		out_item_t   px;
		int unsigned sw, sh, cols, rows, bx, by, nx, ny, fx, fy, s, base;
		sw = clamp_dim(src_w, 2);
		sh = clamp_dim(src_h, 2);
		cols = clamp_dim(dst_w, 8) & ~7;
		rows = clamp_dim(dst_h, 8) & ~7;
		bx = x_pos >> 8;
		by = y_pos >> 8;
		fx = x_pos & 8'hFF;
		fy = y_pos & 8'hFF;
		if (bx > sw - 1) bx = sw - 1;
		if (by > sh - 1) by = sh - 1;
		nx = (bx + 1 < sw) ? bx + 1 : sw - 1;
		ny = (by + 1 < sh) ? by + 1 : sh - 1;
		s = (256 - fx) * (256 - fy) * mem_byte(by * sw + bx)
			+ fx * (256 - fy) * mem_byte(by * sw + nx)
			+ (256 - fx) * fy * mem_byte(ny * sw + bx)
			+ fx * fy * mem_byte(ny * sw + nx);
		s = s >> 16;
		px = '0;
		px.luma = (s > 255) ? 8'd255 : 8'(s);
		if (!row_cnt[0] && !col_cnt[0]) begin
			base = sh * sw + (by / 2) * sw + (bx / 2) * 2;
			px.chroma_u = 8'(mem_byte(base));
			px.chroma_v = 8'(mem_byte(base + 1));
			px.chroma_valid = 1'b1;
		end
		px.out_col = col_cnt;
		px.out_row = row_cnt;
		if (col_cnt + 1 >= cols) begin
			col_cnt = '0;
			x_pos = '0;
			if (row_cnt + 1 >= rows) begin
				row_cnt = '0;
				y_pos = '0;
				px.frame_last = 1'b1;
			end else begin
				row_cnt = row_cnt + 1;
				y_pos = y_pos + y_inc;
			end
		end else begin
			col_cnt = col_cnt + 1;
			x_pos = x_pos + x_inc;
		end
		return px;
	endfunction

	// Track register writes, predict on input transfers, compare on output
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			src_w = 128;
			src_h = 128;
			dst_w = 128;
			dst_h = 128;
			col_cnt = '0;
			row_cnt = '0;
			x_pos = '0;
			y_pos = '0;
			update_steps();
			pixel_queue.delete();
			fail_count = 0;
			pending_pixels = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH:  src_w = cfg_wdata;
					REG_SRC_HEIGHT: src_h = cfg_wdata;
					REG_DST_WIDTH:  dst_w = cfg_wdata;
					REG_DST_HEIGHT: dst_h = cfg_wdata;
					default: ;
				endcase
				update_steps();
			end
			if (in_valid && in_ready) begin
				if (in_data.kind == KIND_WRITE) begin
					if (in_data.src_offset < STORE_DEPTH)
						frame_mem[in_data.src_offset] = in_data.src_byte;
				end else begin
					pixel_queue.push_back(next_pixel());
				end
			end
			if (out_valid && out_ready) begin
				if (pixel_queue.size() == 0) begin
					$display("%0t: unexpected pixel %p", $time, out_data);
					fail_count++;
				end else begin
					want = pixel_queue.pop_front();
					if (want !== out_data) begin
						$display("%0t: pixel mismatch expected %p actual %p",
							$time, want, out_data);
						fail_count++;
					end
				end
			end
			pending_pixels = pixel_queue.size();
		end
	end
endmodule

// ----- verif/tb_nv12_bilinear_scaler_core.sv -----
// ----------------------------------------------------------------------------
// NV12 scaler testbench
// Loads source frames, steps out destination pixels under several size
// settings with random gaps on both channels; the checker judges each pixel.
// ----------------------------------------------------------------------------
module tb_nv12_bilinear_scaler_core import nv12s_pkg::*, nv12s_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_wdata = '0;
	int               fail_count, pending_pixels;
	int               idle_cycles = 0;
	int               rx_gap = 0;
	bit               hold_sink = 1'b0;
	bit               timed_out = 1'b0;
	logic [7:0]       cur_sw = 128, cur_sh = 128;

	nv12s_chan_if #(.T(in_item_t))  in_ch ();
	nv12s_chan_if #(.T(out_item_t)) out_ch ();

	nv12_bilinear_scaler_core i_dut (
		.clk, .arst_n, .in_ch, .out_ch, .cfg_we, .cfg_index, .cfg_wdata
	);

	nv12s_scaler_checker i_checker (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending_pixels
	);

	always #4 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random gaps between ready cycles, or a long hold-off when requested
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_sink) begin
				out_ch.ready <= 1'b0;
			end else if (rx_gap != 0) begin
				out_ch.ready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else begin
				out_ch.ready <= 1'b1;
				rx_gap <= gap_len();
			end
		end
	end

	// End the run when nothing is accepted for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_sink)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one item and wait for its transfer, with an optional gap first
	task automatic send_item(input logic kind, input int unsigned ofs,
			input int unsigned val, input bit with_gap);
		int g;
		g = with_gap ? gap_len() : 0;
		repeat (g) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{kind: kind, src_offset: 15'(ofs), src_byte: 8'(val)};
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_pixels != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Write a register while idle and let the step divider finish
	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 8'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (20) @(posedge clk);
		if (idx == REG_SRC_WIDTH) cur_sw = 8'(val);
		if (idx == REG_SRC_HEIGHT) cur_sh = 8'(val);
	endtask

	// Fill the whole store region that the current source size can read
	task automatic load_frame(input bit with_gap, input int mode);
		int unsigned sw, sh, n, v;
		sw = (cur_sw < 2) ? 2 : (cur_sw > 128 ? 128 : cur_sw);
		sh = (cur_sh < 2) ? 2 : (cur_sh > 128 ? 128 : cur_sh);
		n = sw * sh + sw * ((sh + 1) / 2) + 2;
		for (int unsigned a = 0; a < n; a++) begin
			v = (mode == 0) ? 8'hFF : (mode == 1) ? 0 : $urandom_range(0, 255);
			send_item(KIND_WRITE, a, v, with_gap);
		end
	endtask

	task automatic run_phase(input int unsigned sw, input int unsigned sh,
			input int unsigned dw, input int unsigned dh, input int steps);
		drain();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		load_frame(1'b0, 2);
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(KIND_WRITE, $urandom_range(0, 32767), $urandom_range(0, 255), 1);
			else
				send_item(KIND_STEP, $urandom, $urandom, 1);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (20) @(posedge clk);

		// Directed: small frame with extreme bytes, out-of-range writes and sizes
		write_reg(REG_SRC_WIDTH, 2);
		write_reg(REG_SRC_HEIGHT, 2);
		write_reg(REG_DST_WIDTH, 8);
		write_reg(REG_DST_HEIGHT, 8);
		load_frame(1'b0, 0);
		send_item(KIND_WRITE, 32767, 8'h55, 0);
		send_item(KIND_WRITE, STORE_DEPTH, 8'hAA, 0);
		repeat (10) send_item(KIND_STEP, 15'h7FFF, 8'hFF, 0);
		drain();
		load_frame(1'b0, 1);
		repeat (6) send_item(KIND_STEP, 0, 0, 0);
		drain();
		write_reg(REG_SRC_WIDTH, 0);
		write_reg(REG_SRC_HEIGHT, 255);
		write_reg(REG_DST_WIDTH, 3);
		write_reg(REG_DST_HEIGHT, 255);
		write_reg(8'd7, 9);
		write_reg(8'hFF, 0);
		// Chroma pair that the next row reads at the clamped sizes
		send_item(KIND_WRITE, 256, 8'h3C, 0);
		send_item(KIND_WRITE, 257, 8'hC3, 0);

		// Long receiver hold-off while the sender keeps offering steps
		fork
			begin
				hold_sink = 1'b1;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
			repeat (8) send_item(KIND_STEP, 0, 0, 0);
		join

		// Random phases over a range of sizes, small frames mostly
		run_phase(40, 4, 128, 128, 150);
		run_phase(9, 5, 16, 8, 150);
		run_phase(3, 4, 17, 23, 150);
		run_phase(2, 2, 127, 9, 150);
		run_phase(6, 3, 8, 8, 150);
		drain();
		// Change sizes mid-frame, then wrap
		write_reg(REG_DST_WIDTH, 8);
		write_reg(REG_DST_HEIGHT, 8);
		repeat (100) send_item(KIND_STEP, 0, 0, 1);
		drain();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ----- nv12_bilinear_scaler_core.f -----
+incdir+hw/rtl
hw/rtl/nv12s_pkg.sv
hw/rtl/nv12s_chan_if.sv
hw/rtl/nv12s_ram.sv
hw/rtl/nv12s_step_div.sv
hw/rtl/nv12_bilinear_scaler_core.sv
verif/nv12s_tb_pkg.sv
verif/nv12s_scaler_checker.sv
verif/tb_nv12_bilinear_scaler_core.sv
